### rtl/core/grmt_pkg.sv
package grmt_pkg;

    // walk parameter, unsigned Q2.16
    localparam int unsigned T_W   = 18;
    localparam logic [T_W-1:0] T_ONE = 18'd65536;
    localparam logic [T_W-1:0] T_INF = 18'd131072;

    // cell numbers carry two guard bits over the 24-bit Q15.8 coordinates
    localparam int unsigned CELL_W = 26;
    localparam int unsigned DLT_W  = 25;
    localparam int unsigned NUM_W  = 33;
    localparam int unsigned REM_W  = 26;
    localparam int unsigned PROD_W = 43;

    localparam logic [15:0] CELL_SIZE_ONE = 16'd256;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CELL_SIZE = 3'd0,
        CFG_ORIGIN_X  = 3'd1,
        CFG_ORIGIN_Y  = 3'd2,
        CFG_WIDTH     = 3'd3,
        CFG_HEIGHT    = 3'd4
    } cfg_idx_t;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // setup divisions, in issue order
    typedef enum logic [2:0] {
        OP_FX  = 3'd0,
        OP_FY  = 3'd1,
        OP_TX  = 3'd2,
        OP_TY  = 3'd3,
        OP_TDX = 3'd4,
        OP_TDY = 3'd5,
        OP_TMX = 3'd6,
        OP_TMY = 3'd7
    } div_op_t;

endpackage

### rtl/core/grid_ray_mask_traversal_top.sv
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | cmd, cell_index, cell_mask, from/to x/y, probe
// m_      | out       | m_valid / m_ready  | hit, impact x/y, hit cell x/y, hit_channels
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
// a cast runs up to eight setup divisions in one shared radix-2 divider, plus one
// store read per visited cell and the impact multiply on a hit past the start cell
// after reset all MAX_WIDTH*MAX_HEIGHT store entries are swept to zero, s_ready low
// a finished result waits in the output register; a new transaction is taken meanwhile
module grid_ray_mask_traversal_top
    import grmt_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 64,
    parameter int unsigned MAX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [11:0] s_cell_index,
    input  logic [31:0] s_cell_mask,
    input  logic signed [23:0] s_from_x,
    input  logic signed [23:0] s_from_y,
    input  logic signed [23:0] s_to_x,
    input  logic signed [23:0] s_to_y,
    input  logic [31:0] s_probe_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic signed [23:0] m_impact_x,
    output logic signed [23:0] m_impact_y,
    output logic signed [15:0] m_hit_cell_x,
    output logic signed [15:0] m_hit_cell_y,
    output logic [31:0] m_hit_channels,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned IW    = (AW > 12) ? AW : 12;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DSET, ST_DIV, ST_DFIN, ST_LOOK, ST_LCHK,
        ST_WSTEP, ST_LX, ST_LY, ST_LZ, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0]       cs_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic [6:0]        gw_reg, gh_reg;

    // transaction operands
    logic signed [23:0] fx_reg, fy_reg, tx_reg, ty_reg;
    logic signed [DLT_W-1:0] dx_reg, dy_reg;
    logic [31:0]       probe_reg;

    // shared divider
    div_op_t           op_reg;
    logic [5:0]        cnt_reg;
    logic [NUM_W-1:0]  nq_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DLT_W-1:0]  dvs_reg;

    // walk state
    logic signed [CELL_W-1:0] cx_reg, cy_reg, ex_reg, ey_reg;
    logic [15:0]       rx_reg, ry_reg;
    logic [T_W-1:0]    tdx_reg, tdy_reg, tmx_reg, tmy_reg, thit_reg;
    logic [9:0]        guard_reg;
    logic              start_reg;
    logic              inr_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // result
    logic              res_hit_reg;
    logic [23:0]       res_ix_reg, res_iy_reg;
    logic [15:0]       res_cx_reg, res_cy_reg;
    logic [31:0]       res_ch_reg;

    // output register
    logic              m_valid_reg, m_hit_reg;
    logic [23:0]       m_ix_reg, m_iy_reg;
    logic [15:0]       m_cx_reg, m_cy_reg;
    logic [31:0]       m_ch_reg;

    // store
    logic [31:0]       mem [DEPTH];
    logic [31:0]       rd_reg;
    logic [AW-1:0]     clr_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [31:0]       mem_wdata;
    logic [AW-1:0]     rd_addr;

    // effective grid size
    logic [8:0] ew, eh;
    assign ew = (9'(gw_reg) > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : 9'(gw_reg);
    assign eh = (9'(gh_reg) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(gh_reg);

    // store address of the current cell and its range check
    logic signed [CELL_W:0] lx, ly;
    logic        in_range;
    logic [17:0] lin;
    assign lx = (CELL_W+1)'(cx_reg) - (CELL_W+1)'(ox_reg);
    assign ly = (CELL_W+1)'(cy_reg) - (CELL_W+1)'(oy_reg);
    assign in_range = !lx[CELL_W] && !ly[CELL_W]
                      && (lx < (CELL_W+1)'(ew)) && (ly < (CELL_W+1)'(eh));
    assign lin = 18'(ly[8:0]) * 18'(ew) + 18'(lx[8:0]);
    assign rd_addr = AW'(lin);

    // write command index check
    logic [IW:0] widx;
    assign widx = (IW+1)'(s_cell_index);

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // output register load
    logic m_load;
    assign m_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // store port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (s_fire && s_cmd == CMD_WRITE && widx < (IW+1)'(DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(widx);
            mem_wdata = s_cell_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    // divider operand selection
    logic [NUM_W-1:0] div_n;
    logic [DLT_W-1:0] div_d;
    logic [DLT_W-1:0] adx, ady;
    logic [16:0]      anx, any_;
    assign adx  = dx_reg[DLT_W-1] ? DLT_W'(-dx_reg) : DLT_W'(dx_reg);
    assign ady  = dy_reg[DLT_W-1] ? DLT_W'(-dy_reg) : DLT_W'(dy_reg);
    assign anx  = (dx_reg > 0) ? (17'(cs_reg) - 17'(rx_reg)) : 17'(rx_reg);
    assign any_ = (dy_reg > 0) ? (17'(cs_reg) - 17'(ry_reg)) : 17'(ry_reg);

    always_comb begin
        div_d = DLT_W'(cs_reg);
        unique case (op_reg)
            OP_FX:  div_n = NUM_W'($unsigned(fx_reg[23] ? -fx_reg : fx_reg));
            OP_FY:  div_n = NUM_W'($unsigned(fy_reg[23] ? -fy_reg : fy_reg));
            OP_TX:  div_n = NUM_W'($unsigned(tx_reg[23] ? -tx_reg : tx_reg));
            OP_TY:  div_n = NUM_W'($unsigned(ty_reg[23] ? -ty_reg : ty_reg));
            OP_TDX: begin div_n = {1'b0, cs_reg, 16'd0}; div_d = adx; end
            OP_TDY: begin div_n = {1'b0, cs_reg, 16'd0}; div_d = ady; end
            OP_TMX: begin div_n = {anx, 16'd0}; div_d = adx; end
            OP_TMY: begin div_n = {any_, 16'd0}; div_d = ady; end
            default: div_n = '0;
        endcase
    end

    // one restoring divider step
    logic [REM_W-1:0] rem_sh;
    logic             q_bit;
    assign rem_sh = {rem_reg[REM_W-2:0], nq_reg[NUM_W-1]};
    assign q_bit  = rem_sh >= REM_W'(dvs_reg);

    // floor quotient and remainder of the finished division
    logic              op_neg;
    logic [CELL_W-1:0] q_cell, fl_cell;
    logic [15:0]       fl_rem;
    logic [T_W-1:0]    q_sat;
    logic              rem_nz;
    always_comb begin
        unique case (op_reg)
            OP_FX:   op_neg = fx_reg[23];
            OP_FY:   op_neg = fy_reg[23];
            OP_TX:   op_neg = tx_reg[23];
            OP_TY:   op_neg = ty_reg[23];
            default: op_neg = 1'b0;
        endcase
    end
    assign rem_nz = rem_reg != '0;
    assign q_cell = CELL_W'(nq_reg[23:0]);
    assign fl_cell = !op_neg ? q_cell : (rem_nz ? (-q_cell - CELL_W'(1)) : -q_cell);
    assign fl_rem  = !op_neg ? rem_reg[15:0] : (rem_nz ? (cs_reg - rem_reg[15:0]) : 16'd0);
    assign q_sat   = (nq_reg > NUM_W'(T_INF)) ? T_INF : nq_reg[T_W-1:0];

    // walk step arithmetic
    logic [T_W:0] tmx_sum, tmy_sum;
    logic [T_W-1:0] tmx_nx, tmy_nx;
    assign tmx_sum = (T_W+1)'(tmx_reg) + (T_W+1)'(tdx_reg);
    assign tmy_sum = (T_W+1)'(tmy_reg) + (T_W+1)'(tdy_reg);
    assign tmx_nx  = (tmx_sum > (T_W+1)'(T_INF)) ? T_INF : tmx_sum[T_W-1:0];
    assign tmy_nx  = (tmy_sum > (T_W+1)'(T_INF)) ? T_INF : tmy_sum[T_W-1:0];

    logic signed [CELL_W-1:0] sx, sy;
    assign sx = (dx_reg > 0) ? CELL_W'(1) : ((dx_reg < 0) ? -CELL_W'(1) : '0);
    assign sy = (dy_reg > 0) ? CELL_W'(1) : ((dy_reg < 0) ? -CELL_W'(1) : '0);

    logic [31:0] match;
    assign match = inr_reg ? (rd_reg & probe_reg) : 32'd0;

    // impact rounding, halves toward plus infinity
    logic signed [PROD_W-1:0] prod_rnd;
    logic [23:0] lerp_off;
    assign prod_rnd = prod_reg + PROD_W'(32768);
    assign lerp_off = 24'(prod_rnd >>> 16);

    logic [T_W-1:0] thit_lo;
    assign thit_lo = thit_reg;

    // sequencer, configuration and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            cs_reg      <= CELL_SIZE_ONE;
            ox_reg      <= '0;
            oy_reg      <= '0;
            gw_reg      <= '0;
            gh_reg      <= '0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_CELL_SIZE: cs_reg <= (cfg_data == 16'd0) ? CELL_SIZE_ONE : cfg_data;
                    CFG_ORIGIN_X:  ox_reg <= cfg_data;
                    CFG_ORIGIN_Y:  oy_reg <= cfg_data;
                    CFG_WIDTH:     gw_reg <= cfg_data[6:0];
                    CFG_HEIGHT:    gh_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        res_hit_reg <= 1'b0;
                        res_ix_reg  <= '0;
                        res_iy_reg  <= '0;
                        res_cx_reg  <= '0;
                        res_cy_reg  <= '0;
                        res_ch_reg  <= '0;
                        fx_reg      <= s_from_x;
                        fy_reg      <= s_from_y;
                        tx_reg      <= s_to_x;
                        ty_reg      <= s_to_y;
                        dx_reg      <= DLT_W'(s_to_x) - DLT_W'(s_from_x);
                        dy_reg      <= DLT_W'(s_to_y) - DLT_W'(s_from_y);
                        probe_reg   <= s_probe_mask;
                        guard_reg   <= 10'(ew) + 10'(eh) + 10'd2;
                        op_reg      <= OP_FX;
                        if (s_cmd == CMD_WRITE || ew == '0 || eh == '0
                            || s_probe_mask == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_DSET;
                        end
                    end
                end
                ST_DSET: begin
                    nq_reg    <= div_n;
                    dvs_reg   <= div_d;
                    rem_reg   <= '0;
                    cnt_reg   <= 6'(NUM_W);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= q_bit ? (rem_sh - REM_W'(dvs_reg)) : rem_sh;
                    nq_reg  <= {nq_reg[NUM_W-2:0], q_bit};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= ST_DFIN;
                    end
                end
                ST_DFIN: begin
                    unique case (op_reg)
                        OP_FX:  begin cx_reg <= fl_cell; rx_reg <= fl_rem; end
                        OP_FY:  begin cy_reg <= fl_cell; ry_reg <= fl_rem; end
                        OP_TX:  ex_reg  <= fl_cell;
                        OP_TY:  ey_reg  <= fl_cell;
                        OP_TDX: tdx_reg <= q_sat;
                        OP_TDY: tdy_reg <= q_sat;
                        OP_TMX: tmx_reg <= q_sat;
                        OP_TMY: tmy_reg <= q_sat;
                        default: ;
                    endcase
                    if (op_reg == OP_FY) begin
                        start_reg <= 1'b1;
                        state_reg <= ST_LOOK;
                    end else if (op_reg == OP_TMY) begin
                        state_reg <= ST_WSTEP;
                    end else begin
                        op_reg    <= div_op_t'(op_reg + 3'd1);
                        state_reg <= ST_DSET;
                    end
                end
                ST_LOOK: begin
                    // store read issued this cycle
                    inr_reg   <= in_range;
                    state_reg <= ST_LCHK;
                end
                ST_LCHK: begin
                    if (match != '0) begin
                        res_hit_reg <= 1'b1;
                        res_cx_reg  <= cx_reg[15:0];
                        res_cy_reg  <= cy_reg[15:0];
                        res_ch_reg  <= match;
                        if (start_reg) begin
                            res_ix_reg <= fx_reg;
                            res_iy_reg <= fy_reg;
                            state_reg  <= ST_DONE;
                        end else begin
                            state_reg <= ST_LX;
                        end
                    end else if (start_reg) begin
                        start_reg <= 1'b0;
                        op_reg    <= OP_TX;
                        state_reg <= ST_DSET;
                    end else if ((cx_reg == ex_reg && cy_reg == ey_reg)
                                 || guard_reg == 10'd1) begin
                        state_reg <= ST_DONE;
                    end else begin
                        guard_reg <= guard_reg - 10'd1;
                        state_reg <= ST_WSTEP;
                    end
                end
                ST_WSTEP: begin
                    // smaller boundary time steps; a tie steps in y
                    if (tmx_reg < tmy_reg) begin
                        if (tmx_reg > T_ONE) begin
                            state_reg <= ST_DONE;
                        end else begin
                            cx_reg    <= cx_reg + sx;
                            thit_reg  <= tmx_reg;
                            tmx_reg   <= tmx_nx;
                            state_reg <= ST_LOOK;
                        end
                    end else begin
                        if (tmy_reg > T_ONE) begin
                            state_reg <= ST_DONE;
                        end else begin
                            cy_reg    <= cy_reg + sy;
                            thit_reg  <= tmy_reg;
                            tmy_reg   <= tmy_nx;
                            state_reg <= ST_LOOK;
                        end
                    end
                end
                ST_LX: begin
                    prod_reg  <= PROD_W'(dx_reg) * PROD_W'($signed({1'b0, thit_lo}));
                    state_reg <= ST_LY;
                end
                ST_LY: begin
                    res_ix_reg <= fx_reg + lerp_off;
                    prod_reg   <= PROD_W'(dy_reg) * PROD_W'($signed({1'b0, thit_lo}));
                    state_reg  <= ST_LZ;
                end
                ST_LZ: begin
                    res_iy_reg <= fy_reg + lerp_off;
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (m_load) begin
                        m_hit_reg   <= res_hit_reg;
                        m_ix_reg    <= res_ix_reg;
                        m_iy_reg    <= res_iy_reg;
                        m_cx_reg    <= res_cx_reg;
                        m_cy_reg    <= res_cy_reg;
                        m_ch_reg    <= res_ch_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = state_reg == ST_IDLE;
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_impact_x     = m_ix_reg;
    assign m_impact_y     = m_iy_reg;
    assign m_hit_cell_x   = m_cx_reg;
    assign m_hit_cell_y   = m_cy_reg;
    assign m_hit_channels = m_ch_reg;

endmodule

### rtl/core/grmt_checker.sv
module grmt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [23:0] m_impact_x,
    input logic [23:0] m_impact_y,
    input logic [15:0] m_hit_cell_x,
    input logic [15:0] m_hit_cell_y,
    input logic [31:0] m_hit_channels
);

    // a pending result stays until taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transaction");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_impact_x == '0 && m_impact_y == '0
            && m_hit_cell_x == '0 && m_hit_cell_y == '0 && m_hit_channels == '0)
        else $error("miss with nonzero fields");

    // a hit always names matched channels
    a_hit_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_hit_channels != '0)
        else $error("hit without channels");

    // one transaction at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind grid_ray_mask_traversal_top grmt_checker u_grmt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hit          (m_hit),
    .m_impact_x     (m_impact_x),
    .m_impact_y     (m_impact_y),
    .m_hit_cell_x   (m_hit_cell_x),
    .m_hit_cell_y   (m_hit_cell_y),
    .m_hit_channels (m_hit_channels)
);

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import grmt_pkg::*;

    localparam int MAXW = 64;
    localparam int MAXH = 64;
    localparam int DEPTH = MAXW * MAXH;
    localparam longint TONE = 65536;
    localparam longint TINF = 131072;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic        cmd;
        logic [11:0] cell_index;
        logic [31:0] cell_mask;
        logic [23:0] from_x;
        logic [23:0] from_y;
        logic [23:0] to_x;
        logic [23:0] to_y;
        logic [31:0] probe_mask;
    } ray_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [23:0] impact_x;
        logic [23:0] impact_y;
        logic [15:0] cell_x;
        logic [15:0] cell_y;
        logic [31:0] channels;
    } ray_hit_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_cmd;
    logic [11:0] s_cell_index;
    logic [31:0] s_cell_mask;
    logic signed [23:0] s_from_x;
    logic signed [23:0] s_from_y;
    logic signed [23:0] s_to_x;
    logic signed [23:0] s_to_y;
    logic [31:0] s_probe_mask;
    logic        m_valid;
    logic        m_ready;
    logic        m_hit;
    logic signed [23:0] m_impact_x;
    logic signed [23:0] m_impact_y;
    logic signed [15:0] m_hit_cell_x;
    logic signed [15:0] m_hit_cell_y;
    logic [31:0] m_hit_channels;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    grid_ray_mask_traversal_top dut (.*);

    // predictor state
    logic [31:0] mask_store [DEPTH];
    longint      p_cell_size;
    longint      p_org_x;
    longint      p_org_y;
    int          p_width;
    int          p_height;

    ray_cmd_t pending_cmds [$];
    ray_hit_t expected_hits [$];
    int       errors;
    int       idle_cycles;
    bit       stall_hold;
    int       stall_len;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_q(longint a, longint b);
        if (a >= 0) return a / b;
        return -((-a + b - 1) / b);
    endfunction

    function automatic int eff_w();
        return (p_width > MAXW) ? MAXW : p_width;
    endfunction

    function automatic int eff_h();
        return (p_height > MAXH) ? MAXH : p_height;
    endfunction

    function automatic logic [31:0] mask_at(longint cx, longint cy);
        longint lx, ly;
        lx = cx - p_org_x;
        ly = cy - p_org_y;
        if (lx < 0 || ly < 0 || lx >= eff_w() || ly >= eff_h()) return 32'd0;
        return mask_store[ly * eff_w() + lx];
    endfunction

    function automatic longint t_clip(longint t);
        return (t > TINF) ? TINF : t;
    endfunction

    function automatic longint t_boundary(longint from, longint d, longint c, longint cs);
        longint num;
        if (d == 0) return TINF;
        num = (c + (d > 0 ? 1 : 0)) * cs - from;
        if (num < 0) num = -num;
        return t_clip((num << 16) / (d < 0 ? -d : d));
    endfunction

    function automatic longint t_per_cell(longint d, longint cs);
        if (d == 0) return TINF;
        return t_clip((cs << 16) / (d < 0 ? -d : d));
    endfunction

    function automatic longint point_at(longint from, longint d, longint t);
        return from + floor_q(d * t + 32768, 65536);
    endfunction

    function automatic ray_hit_t make_hit(longint ix, longint iy, longint cx, longint cy,
                                          logic [31:0] ch);
        ray_hit_t r;
        r.hit = 1'b1;
        r.impact_x = ix[23:0];
        r.impact_y = iy[23:0];
        r.cell_x = cx[15:0];
        r.cell_y = cy[15:0];
        r.channels = ch;
        return r;
    endfunction

    // applies a write to the store, or walks the segment and returns the first matching cell
    function automatic ray_hit_t cast_ray(ray_cmd_t c);
        ray_hit_t r;
        longint fx, fy, tx, ty, dx, dy, cs, cx, cy, ex, ey, sx, sy;
        longint tmx, tmy, tdx, tdy;
        logic [31:0] m;
        int guard;
        r = '0;
        if (c.cmd == CMD_WRITE) begin
            mask_store[c.cell_index] = c.cell_mask;
            return r;
        end
        if (eff_w() == 0 || eff_h() == 0 || c.probe_mask == 0) return r;
        fx = longint'($signed(c.from_x));
        fy = longint'($signed(c.from_y));
        tx = longint'($signed(c.to_x));
        ty = longint'($signed(c.to_y));
        cs = p_cell_size;
        cx = floor_q(fx, cs);
        cy = floor_q(fy, cs);
        m = mask_at(cx, cy) & c.probe_mask;
        if (m != 0) return make_hit(fx, fy, cx, cy, m);
        ex = floor_q(tx, cs);
        ey = floor_q(ty, cs);
        dx = tx - fx;
        dy = ty - fy;
        sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
        sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
        tdx = t_per_cell(dx, cs);
        tdy = t_per_cell(dy, cs);
        tmx = t_boundary(fx, dx, cx, cs);
        tmy = t_boundary(fy, dy, cy, cs);
        for (guard = eff_w() + eff_h() + 2; guard > 0; guard--) begin
            if (tmx < tmy) begin
                if (tmx > TONE) break;
                cx += sx;
                m = mask_at(cx, cy) & c.probe_mask;
                if (m != 0)
                    return make_hit(point_at(fx, dx, tmx), point_at(fy, dy, tmx), cx, cy, m);
                tmx = t_clip(tmx + tdx);
            end else begin
                if (tmy > TONE) break;
                cy += sy;
                m = mask_at(cx, cy) & c.probe_mask;
                if (m != 0)
                    return make_hit(point_at(fx, dx, tmy), point_at(fy, dy, tmy), cx, cy, m);
                tmy = t_clip(tmy + tdy);
            end
            if (cx == ex && cy == ey) break;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // input transaction taken at the last rising edge
    bit in_taken;
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
    end

    // driver
    int send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (s_valid && !in_taken) begin
            // hold the offered transaction
        end else if (send_gap > 0) begin
            s_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
            ray_cmd_t c;
            c = pending_cmds.pop_front();
            s_valid <= 1'b1;
            s_cmd <= c.cmd;
            s_cell_index <= c.cell_index;
            s_cell_mask <= c.cell_mask;
            s_from_x <= c.from_x;
            s_from_y <= c.from_y;
            s_to_x <= c.to_x;
            s_to_y <= c.to_y;
            s_probe_mask <= c.probe_mask;
            send_gap <= gap_len();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver back-pressure
    int recv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            stall_len <= 0;
        end else if (stall_hold) begin
            m_ready <= 1'b0;
            stall_len <= stall_len + 1;
        end else if (recv_gap > 0) begin
            m_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_ready <= 1'b1;
            recv_gap <= gap_len();
        end
    end

    // monitor: predict on input, compare on output
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                ray_cmd_t c;
                c = {s_cmd, s_cell_index, s_cell_mask, s_from_x, s_from_y, s_to_x, s_to_y,
                     s_probe_mask};
                expected_hits.insert(expected_hits.size(), cast_ray(c));
            end
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result transaction", 1, 0);
                end else begin
                    ray_hit_t e;
                    e = expected_hits.pop_front();
                    if (m_hit !== e.hit) report_mismatch("hit", m_hit, e.hit);
                    if (m_impact_x !== e.impact_x)
                        report_mismatch("impact_x", m_impact_x, e.impact_x);
                    if (m_impact_y !== e.impact_y)
                        report_mismatch("impact_y", m_impact_y, e.impact_y);
                    if (m_hit_cell_x !== e.cell_x)
                        report_mismatch("hit_cell_x", m_hit_cell_x, e.cell_x);
                    if (m_hit_cell_y !== e.cell_y)
                        report_mismatch("hit_cell_y", m_hit_cell_y, e.cell_y);
                    if (m_hit_channels !== e.channels)
                        report_mismatch("hit_channels", m_hit_channels, e.channels);
                end
            end
        end
    end

    // watchdog on cycles without any transaction, paused during a held stall
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || stall_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_CELL_SIZE: p_cell_size = (val == 0) ? 256 : val;
            CFG_ORIGIN_X:  p_org_x = longint'($signed(val));
            CFG_ORIGIN_Y:  p_org_y = longint'($signed(val));
            CFG_WIDTH:     p_width = val[6:0];
            CFG_HEIGHT:    p_height = val[6:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_valid || expected_hits.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic add_write(int idx, logic [31:0] m);
        ray_cmd_t c;
        c = '0;
        c.cmd = CMD_WRITE;
        c.cell_index = idx[11:0];
        c.cell_mask = m;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic add_cast(longint fx, longint fy, longint tx, longint ty, logic [31:0] p);
        ray_cmd_t c;
        c = '0;
        c.cmd = CMD_CAST;
        c.cell_index = 12'($urandom);
        c.cell_mask = $urandom;
        c.from_x = fx[23:0];
        c.from_y = fy[23:0];
        c.to_x = tx[23:0];
        c.to_y = ty[23:0];
        c.probe_mask = p;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // random coordinate near the grid, occasionally anywhere
    function automatic longint rand_coord(longint org);
        longint span;
        if ($urandom_range(0, 15) == 0) return longint'($signed(24'($urandom)));
        span = (MAXW + 8) * p_cell_size;
        return org * p_cell_size - 4 * p_cell_size + longint'($urandom_range(0, span));
    endfunction

    task automatic random_phase(int n);
        longint fx, fy;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 9) == 0)
                    add_write($urandom_range(0, DEPTH - 1), $urandom);
                else
                    add_write($urandom_range(0, eff_w() * eff_h() + 1) % DEPTH,
                              ($urandom_range(0, 2) == 0) ? 32'd0 : 32'd1 << $urandom_range(0, 31));
            end else begin
                fx = rand_coord(p_org_x);
                fy = rand_coord(p_org_y);
                if ($urandom_range(0, 5) == 0)
                    add_cast(fx, fy, fx + $urandom_range(0, 3) - 1, fy, $urandom);
                else
                    add_cast(fx, fy, rand_coord(p_org_x), rand_coord(p_org_y),
                             ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom);
            end
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        stall_hold = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CELL_SIZE;
        cfg_data = '0;
        s_cmd = CMD_WRITE;
        s_cell_index = '0;
        s_cell_mask = '0;
        s_from_x = '0;
        s_from_y = '0;
        s_to_x = '0;
        s_to_y = '0;
        s_probe_mask = '0;
        errors = 0;
        idle_cycles = 0;
        foreach (mask_store[i]) mask_store[i] = '0;
        p_cell_size = 256;
        p_org_x = 0;
        p_org_y = 0;
        p_width = 0;
        p_height = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // grid not ready: everything misses
        add_cast(100, 100, 3000, 3000, 32'hFFFF_FFFF);
        add_write(0, 32'h1);
        drain();

        write_reg(CFG_CELL_SIZE, 16'd256);
        write_reg(CFG_ORIGIN_X, 16'd0);
        write_reg(CFG_ORIGIN_Y, 16'd0);
        write_reg(CFG_WIDTH, 16'd8);
        write_reg(CFG_HEIGHT, 16'd8);

        // directed: start cell match, tie, zero probe, outside, index beyond the grid
        add_write(9, 32'h0000_00F0);
        add_write(18, 32'h8000_0001);
        add_write(4095, 32'hFFFF_FFFF);
        add_write(4095, 32'h0);
        add_cast(300, 300, 2000, 300, 32'h10);
        add_cast(300, 300, 2000, 300, 32'h0);
        add_cast(0, 0, 1024, 1024, 32'h1);
        add_cast(100, 100, 700, 700, 32'h8000_0000);
        add_cast(2047, 2047, -2048, -2048, 32'hFFFF_FFFF);
        add_cast(-8388608, -8388608, 8388607, 8388607, 32'hFFFF_FFFF);
        add_cast(8388607, 100, -8388608, 100, 32'hFFFF_FFFF);
        add_cast(600, 100, 600, 2000, 32'h1);
        add_cast(600, 2000, 600, 100, 32'h1);
        add_cast(128, 128, 128, 128, 32'h1);
        add_cast(-500, 300, 5000, 300, 32'hF0);
        drain();

        random_phase(300);

        // long receiver stall while the sender keeps offering
        stall_hold = 1'b1;
        for (int i = 0; i < 40; i++) add_cast(rand_coord(0), rand_coord(0),
                                               rand_coord(0), rand_coord(0), $urandom);
        while (stall_len < 3000) @(posedge aclk);
        stall_hold = 1'b0;
        drain();

        // extremes of the registers
        write_reg(CFG_CELL_SIZE, 16'd0);
        write_reg(CFG_WIDTH, 16'd127);
        write_reg(CFG_HEIGHT, 16'd64);
        write_reg(CFG_ORIGIN_X, 16'h8000);
        write_reg(CFG_ORIGIN_Y, 16'h7FFF);
        random_phase(200);

        write_reg(CFG_CELL_SIZE, 16'd1);
        write_reg(CFG_ORIGIN_X, 16'hFFF0);
        write_reg(CFG_ORIGIN_Y, 16'hFFF8);
        write_reg(CFG_WIDTH, 16'd64);
        write_reg(CFG_HEIGHT, 16'd127);
        random_phase(300);

        write_reg(CFG_CELL_SIZE, 16'hFFFF);
        write_reg(CFG_ORIGIN_X, 16'd0);
        write_reg(CFG_ORIGIN_Y, 16'd0);
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd1);
        random_phase(200);

        write_reg(CFG_CELL_SIZE, 16'd40);
        write_reg(CFG_ORIGIN_X, 16'd5);
        write_reg(CFG_ORIGIN_Y, 16'hFFFD);
        write_reg(CFG_WIDTH, 16'd16);
        write_reg(CFG_HEIGHT, 16'd12);
        random_phase(500);

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
